FILE: rtl/core/kpcalc_pkg.sv
package kpcalc_pkg;

    // Default operand width; the result field is always 32 bits.
    localparam int unsigned DATA_WIDTH_DEF = 32;

    localparam int unsigned KEY_W      = 8;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STATUS_W   = 2;
    // Value and status packed, padded up to whole bytes.
    localparam int unsigned OUT_DATA_W = ((VALUE_W + STATUS_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - VALUE_W - STATUS_W;

    localparam logic [KEY_W-1:0] KEY_CLEAR  = 8'h63;  // 'c'
    localparam logic [KEY_W-1:0] KEY_EQUALS = 8'h3D;  // '='
    localparam logic [KEY_W-1:0] KEY_MINUS  = 8'h2D;  // '-'
    localparam logic [KEY_W-1:0] KEY_PLUS   = 8'h2B;  // '+'
    localparam logic [KEY_W-1:0] KEY_STAR   = 8'h2A;  // '*'
    localparam logic [KEY_W-1:0] KEY_SLASH  = 8'h2F;  // '/'
    localparam logic [KEY_W-1:0] KEY_ZERO   = 8'h30;  // '0'
    localparam logic [KEY_W-1:0] KEY_NINE   = 8'h39;  // '9'

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DIV_ZERO  = 2'd2,
        ST_NEG_ZERO  = 2'd3
    } calc_status_t;

    typedef enum logic [2:0] {
        OP_PASS,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic key_take;   // parse a key other than '='
        logic eval_take;  // '=' accepted: capture operands, clear the entry state
        logic setup;      // prepare the operation
        logic step;       // one iteration of the shared multiply/divide unit
        logic finish;     // collect the iterative result
        logic out_load;   // move the result into the output register
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic key_is_equals;
        logic needs_iter;
    } dp_stat_t;

endpackage

FILE: rtl/core/kpcalc_muldiv.sv
module kpcalc_muldiv #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             aclk,
    input  logic             load,
    input  logic             step,
    input  logic             is_div,
    input  logic [WIDTH-1:0] opa,
    input  logic [WIDTH-1:0] opb,
    output logic [WIDTH-1:0] result
);

    // Restoring division of magnitudes, or shift-and-add multiplication
    // keeping the low WIDTH bits. Both consume one bit of opa per step.
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] shf_reg;
    logic [WIDTH-1:0] opd_reg;
    logic             div_mode_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] addend;

    assign trial  = {acc_reg, shf_reg[WIDTH-1]} - {1'b0, opd_reg};
    assign addend = shf_reg[WIDTH-1] ? opd_reg : '0;

    always_ff @(posedge aclk) begin
        if (load) begin
            acc_reg      <= '0;
            shf_reg      <= opa;
            opd_reg      <= opb;
            div_mode_reg <= is_div;
        end else if (step) begin
            if (div_mode_reg) begin
                // The sign of the trial difference shows whether the divisor fits.
                if (!trial[WIDTH]) begin
                    acc_reg <= trial[WIDTH-1:0];
                    shf_reg <= {shf_reg[WIDTH-2:0], 1'b1};
                end else begin
                    acc_reg <= {acc_reg[WIDTH-2:0], shf_reg[WIDTH-1]};
                    shf_reg <= {shf_reg[WIDTH-2:0], 1'b0};
                end
            end else begin
                acc_reg <= {acc_reg[WIDTH-2:0], 1'b0} + addend;
                shf_reg <= {shf_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign result = div_mode_reg ? shf_reg : acc_reg;

endmodule

FILE: rtl/core/kpcalc_dp.sv
module kpcalc_dp #(
    parameter int unsigned DATA_WIDTH = kpcalc_pkg::DATA_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [kpcalc_pkg::KEY_W-1:0]       key_code,
    input  kpcalc_pkg::dp_cmd_t                cmd,
    output kpcalc_pkg::dp_stat_t               stat,
    output logic [kpcalc_pkg::VALUE_W-1:0]     out_value,
    output kpcalc_pkg::calc_status_t           out_status
);

    import kpcalc_pkg::*;

    localparam int unsigned W = DATA_WIDTH;

    // Entry state, built up key by key.
    logic               nothing_stored_reg;
    logic [W-1:0]       first_op_reg;
    logic [W-1:0]       second_op_reg;
    logic [KEY_W-1:0]   op_char_reg;
    logic               op_seen_reg;
    logic               first_neg_reg;
    logic               second_neg_reg;
    logic               first_dig_reg;
    logic               malformed_reg;

    // Evaluation state.
    calc_status_t       status_reg;
    op_kind_t           op_reg;
    logic [W-1:0]       a_reg;
    logic [W-1:0]       b_reg;
    logic [W-1:0]       res_reg;
    logic               neg_q_reg;
    logic [VALUE_W-1:0] out_value_reg;
    calc_status_t       out_status_reg;

    logic               key_is_clear;
    logic               key_is_minus;
    logic               key_is_digit;
    logic [W-1:0]       digit;
    logic [W-1:0]       first_acc;
    logic [W-1:0]       second_acc;
    calc_status_t       status_calc;
    op_kind_t           op_calc;
    logic [W-1:0]       a_mag;
    logic [W-1:0]       b_mag;
    logic               md_load;
    logic               md_is_div;
    logic [W-1:0]       md_opa;
    logic [W-1:0]       md_opb;
    logic [W-1:0]       md_result;

    assign key_is_clear       = (key_code == KEY_CLEAR);
    assign key_is_minus       = (key_code == KEY_MINUS);
    assign key_is_digit       = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
    assign stat.key_is_equals = (key_code == KEY_EQUALS);

    // The low nibble of an ASCII digit is its value.
    assign digit      = W'(key_code[3:0]);
    assign first_acc  = (first_op_reg << 3) + (first_op_reg << 1) + digit;
    assign second_acc = (second_op_reg << 3) + (second_op_reg << 1) + digit;

    always_comb begin
        if (malformed_reg) begin
            status_calc = ST_MALFORMED;
        end else if (op_seen_reg && (op_char_reg == KEY_SLASH) && (second_op_reg == '0)) begin
            status_calc = ST_DIV_ZERO;
        end else if ((first_neg_reg && (first_op_reg == '0)) ||
                     (second_neg_reg && (second_op_reg == '0))) begin
            status_calc = ST_NEG_ZERO;
        end else begin
            status_calc = ST_OK;
        end
    end

    always_comb begin
        if (!op_seen_reg) begin
            op_calc = OP_PASS;
        end else begin
            unique case (op_char_reg)
                KEY_PLUS:  op_calc = OP_ADD;
                KEY_MINUS: op_calc = OP_SUB;
                KEY_STAR:  op_calc = OP_MUL;
                KEY_SLASH: op_calc = OP_DIV;
                default:   op_calc = OP_PASS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.eval_take) begin
            nothing_stored_reg <= 1'b1;
            first_op_reg       <= '0;
            second_op_reg      <= '0;
            op_char_reg        <= '0;
            op_seen_reg        <= 1'b0;
            first_neg_reg      <= 1'b0;
            second_neg_reg     <= 1'b0;
            first_dig_reg      <= 1'b0;
            malformed_reg      <= 1'b0;
        end else if (cmd.key_take && !key_is_clear) begin
            nothing_stored_reg <= 1'b0;
            if (nothing_stored_reg && key_is_minus) begin
                first_neg_reg <= 1'b1;
            end else if (op_seen_reg && key_is_minus) begin
                second_neg_reg <= 1'b1;
            end else if (key_is_digit) begin
                if (!op_seen_reg) begin
                    first_op_reg  <= first_acc;
                    first_dig_reg <= 1'b1;
                end else begin
                    second_op_reg <= second_acc;
                end
            end else if (!op_seen_reg && first_dig_reg) begin
                op_char_reg <= key_code;
                op_seen_reg <= 1'b1;
            end else begin
                malformed_reg <= 1'b1;
            end
        end
    end

    assign a_mag = a_reg[W-1] ? -a_reg : a_reg;
    assign b_mag = b_reg[W-1] ? -b_reg : b_reg;

    assign md_load   = cmd.setup;
    assign md_is_div = (op_reg == OP_DIV);
    assign md_opa    = md_is_div ? a_mag : a_reg;
    assign md_opb    = md_is_div ? b_mag : b_reg;

    assign stat.needs_iter = (status_reg == ST_OK) && ((op_reg == OP_MUL) || (op_reg == OP_DIV));

    always_ff @(posedge aclk) begin
        if (cmd.eval_take) begin
            status_reg <= status_calc;
            op_reg     <= op_calc;
            a_reg      <= first_neg_reg ? -first_op_reg : first_op_reg;
            b_reg      <= second_neg_reg ? -second_op_reg : second_op_reg;
        end
        if (cmd.setup) begin
            neg_q_reg <= a_reg[W-1] ^ b_reg[W-1];
            case (op_reg)
                OP_ADD:  res_reg <= a_reg + b_reg;
                OP_SUB:  res_reg <= a_reg - b_reg;
                default: res_reg <= a_reg;
            endcase
        end
        if (cmd.finish) begin
            if (op_reg == OP_MUL) begin
                res_reg <= md_result;
            end else if (op_reg == OP_DIV) begin
                res_reg <= neg_q_reg ? -md_result : md_result;
            end
        end
        if (cmd.out_load) begin
            out_value_reg  <= (status_reg == ST_OK) ? VALUE_W'(signed'(res_reg)) : '0;
            out_status_reg <= status_reg;
        end
    end

    kpcalc_muldiv #(
        .WIDTH (W)
    ) u_muldiv (
        .aclk   (aclk),
        .load   (md_load),
        .step   (cmd.step),
        .is_div (md_is_div),
        .opa    (md_opa),
        .opb    (md_opb),
        .result (md_result)
    );

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

FILE: rtl/core/kpcalc_ctrl.sv
module kpcalc_ctrl #(
    parameter int unsigned DATA_WIDTH = kpcalc_pkg::DATA_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  kpcalc_pkg::dp_stat_t stat,
    output kpcalc_pkg::dp_cmd_t  cmd
);

    import kpcalc_pkg::*;

    localparam int unsigned CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ITER,
        S_FINISH,
        S_HOLD
    } state_t;

    state_t           state_reg;
    logic             m_tvalid_reg;
    logic [CNT_W-1:0] count_reg;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            // A new result may replace one that is taken at this very edge.
            if ((state_reg == S_HOLD) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && stat.key_is_equals) begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    count_reg <= CNT_W'(DATA_WIDTH - 1);
                    state_reg <= stat.needs_iter ? S_ITER : S_FINISH;
                end
                S_ITER: begin
                    if (count_reg == '0) begin
                        state_reg <= S_FINISH;
                    end else begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                S_FINISH: begin
                    state_reg <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        cmd.key_take  = (state_reg == S_IDLE) && s_tvalid && !stat.key_is_equals;
        cmd.eval_take = (state_reg == S_IDLE) && s_tvalid && stat.key_is_equals;
        cmd.setup     = (state_reg == S_SETUP);
        cmd.step      = (state_reg == S_ITER);
        cmd.finish    = (state_reg == S_FINISH);
        cmd.out_load  = (state_reg == S_HOLD) && out_free;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/core/keypad_two_operand_calculator.sv
// Two-operand keypad calculator. Each input word is one ASCII keystroke: 'c' is ignored, a
// leading '-' negates operand one, digits build the operands (wrapping at DATA_WIDTH bits),
// the first non-digit after a digit of operand one is the operator, and after it any '-'
// negates operand two. On '=' the block sends one output word carrying the value and a status
// (0 ok, 1 malformed entry, 2 division by zero, 3 negated zero operand) and clears itself;
// the value is zero whenever the status is not ok. Ordinary keys are taken whenever the block
// is idle. Once an '=' is taken, no word is accepted while the controller steps through setup,
// iteration when the operator is '*' or '/' and the status is ok (the shared shift-and-add
// multiplier and restoring divider retire one bit per cycle), finish and hold; hold loads the
// result word once the output register is free. A finished result waits in the output
// register and keystrokes continue to be accepted meanwhile; only a following '=' has to wait,
// in its hold state, until the earlier word has been taken.
module keypad_two_operand_calculator #(
    parameter int unsigned DATA_WIDTH = kpcalc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Keystroke channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kpcalc_pkg::KEY_W-1:0]        s_tdata,   // [7:0] key_code
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kpcalc_pkg::OUT_DATA_W-1:0]   m_tdata    // [31:0] value, [33:32] status
);

    import kpcalc_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [VALUE_W-1:0] out_value;
    calc_status_t       out_status;

    // The controller sequences each keystroke and the evaluation on '='.
    kpcalc_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the operands, the arithmetic and the output register.
    kpcalc_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key_code   (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_value  (out_value),
        .out_status (out_status)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_status, out_value};

    // Once '=' is taken, the block is busy evaluating and takes no further word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata == KEY_EQUALS)) |=> !s_tready)
        else $error("keystroke accepted during evaluation");

    // A new result only appears at the end of an evaluation, never while idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised without an evaluation");

    // A failed evaluation carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[VALUE_W +: STATUS_W] != ST_OK)) |-> (m_tdata[VALUE_W-1:0] == '0))
        else $error("non-zero value with error status");

endmodule
